/* hw/rtl/scl_pkg.sv */
// Shared types and constants for the serial command line parser.
// No dependencies; used by every module of the block.
`default_nettype none

package scl_pkg;

   // Longest line buffer, counting the terminator slot
   localparam int LINE_BUFFER_BYTES_DEFAULT = 32;
   // Entries between the line front end and the command back end
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_M     = 8'h4D;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_F     = 8'h46;
   localparam logic [7:0] CHAR_V     = 8'h56;
   localparam logic [7:0] CHAR_O     = 8'h4F;

   localparam logic [31:0] MAG_LIMIT     = 32'h8000_0000;
   localparam logic [31:0] MAG_SAT_START = MAG_LIMIT / 32'd10 + 32'd1;
   localparam logic [31:0] INT_MAX       = 32'h7FFF_FFFF;
   localparam logic [31:0] SERVO_MAX     = 32'd1000;
   localparam logic [31:0] BAND_SEL_MAX  = 32'd2;

   typedef enum logic [1:0] {
      PHASE_SKIP   = 2'd0,
      PHASE_DIGITS = 2'd1,
      PHASE_DONE   = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      CMD_THRESHOLD   = 3'd0,
      CMD_MODE        = 3'd1,
      CMD_BAND_MASK   = 3'd2,
      CMD_BAND_SELECT = 3'd3,
      CMD_SERVO_HOLD  = 3'd4,
      CMD_OSC_ENABLE  = 3'd5
   } cmd_type;

   // One finished line that had a letter and a comma
   typedef struct packed {
      logic [7:0]  letter;
      logic        negative;
      logic [31:0] magnitude;
   } line_type;

endpackage

`default_nettype wire

/* hw/rtl/scl_front.sv */
// Line front end: takes bytes, tracks the line and accumulates the number.
// Depends on scl_pkg; pushes finished lines into scl_queue.
`default_nettype none

module scl_front #(
   parameter int LINE_BUFFER_BYTES = scl_pkg::LINE_BUFFER_BYTES_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              byte_valid,
   input  wire logic [7:0]        byte_data,
   input  wire logic              queue_full,
   output scl_pkg::line_type      push_data,
   output logic                   push_valid,
   output logic                   byte_ready
);

   localparam int LEN_W = $clog2(LINE_BUFFER_BYTES);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BUFFER_BYTES - 1);

   logic [LEN_W-1:0]   length_ff, length_in;
   logic [7:0]         letter_ff, letter_in;
   logic               comma_ff, comma_in;
   scl_pkg::phase_type phase_ff, phase_in;
   logic               negative_ff, negative_in;
   logic [31:0]        magnitude_ff, magnitude_in;

   logic        accept;
   logic        line_end;
   logic        is_digit;
   logic        is_space;
   logic [31:0] scaled;

   assign byte_ready = !queue_full;
   assign accept     = byte_valid && byte_ready;
   assign line_end   = (byte_data == scl_pkg::CHAR_LF) || (byte_data == scl_pkg::CHAR_CR);
   assign is_digit   = (byte_data >= scl_pkg::CHAR_ZERO) && (byte_data <= scl_pkg::CHAR_NINE);
   assign is_space   = (byte_data == scl_pkg::CHAR_SPACE) || (byte_data == scl_pkg::CHAR_TAB) ||
                       (byte_data == scl_pkg::CHAR_VT) || (byte_data == scl_pkg::CHAR_FF);
   // magnitude is below MAG_SAT_START where this is used, so no carry is lost
   assign scaled     = {magnitude_ff[28:0], 3'b000} + {magnitude_ff[30:0], 1'b0} +
                       {28'd0, byte_data[3:0]};

   assign push_valid          = accept && line_end && comma_ff;
   assign push_data.letter    = letter_ff;
   assign push_data.negative  = negative_ff;
   assign push_data.magnitude = magnitude_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         letter_ff    <= '0;
         comma_ff     <= 1'b0;
         phase_ff     <= scl_pkg::PHASE_SKIP;
         negative_ff  <= 1'b0;
         magnitude_ff <= '0;
      end else begin
         length_ff    <= length_in;
         letter_ff    <= letter_in;
         comma_ff     <= comma_in;
         phase_ff     <= phase_in;
         negative_ff  <= negative_in;
         magnitude_ff <= magnitude_in;
      end
   end

   always_comb begin
      scl_pkg::phase_type ph;
      ph           = phase_ff;
      length_in    = length_ff;
      letter_in    = letter_ff;
      comma_in     = comma_ff;
      phase_in     = phase_ff;
      negative_in  = negative_ff;
      magnitude_in = magnitude_ff;
      if (accept) begin
         if (line_end) begin
            length_in    = '0;
            letter_in    = '0;
            comma_in     = 1'b0;
            phase_in     = scl_pkg::PHASE_SKIP;
            negative_in  = 1'b0;
            magnitude_in = '0;
         end else if (length_ff < LEN_MAX) begin
            length_in = length_ff + 1'b1;
            if (length_ff == '0) begin
               letter_in = byte_data;
            end else if (length_ff == LEN_W'(1)) begin
               comma_in = (byte_data == scl_pkg::CHAR_COMMA);
            end else begin
               // Leading whitespace and sign, then digits until a non-digit
               case (phase_ff)
                  scl_pkg::PHASE_SKIP: begin
                     if (is_space) begin
                        ph = scl_pkg::PHASE_SKIP;
                     end else if ((byte_data == scl_pkg::CHAR_MINUS) ||
                                  (byte_data == scl_pkg::CHAR_PLUS)) begin
                        negative_in = (byte_data == scl_pkg::CHAR_MINUS);
                        ph          = scl_pkg::PHASE_DONE;
                        phase_in    = scl_pkg::PHASE_DIGITS;
                     end else begin
                        ph = scl_pkg::PHASE_DIGITS;
                     end
                  end
                  scl_pkg::PHASE_DIGITS: ph = scl_pkg::PHASE_DIGITS;
                  default:               ph = scl_pkg::PHASE_DONE;
               endcase
               if (ph == scl_pkg::PHASE_DIGITS) begin
                  if (is_digit) begin
                     phase_in = scl_pkg::PHASE_DIGITS;
                     if (magnitude_ff >= scl_pkg::MAG_SAT_START) begin
                        magnitude_in = scl_pkg::MAG_LIMIT;
                     end else if (scaled > scl_pkg::MAG_LIMIT) begin
                        magnitude_in = scl_pkg::MAG_LIMIT;
                     end else begin
                        magnitude_in = scaled;
                     end
                  end else begin
                     phase_in = scl_pkg::PHASE_DONE;
                  end
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/scl_queue.sv */
// Short queue of finished lines between the front end and the back end.
// Depends on scl_pkg for the line entry type.
`default_nettype none

module scl_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire scl_pkg::line_type push_data,
   output logic                   full,
   output logic                   pop_valid,
   output scl_pkg::line_type      pop_data,
   input  wire logic              pop_ready
);

   localparam int DEPTH = scl_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   scl_pkg::line_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/scl_back.sv */
// Command back end: decodes a finished line into a command and its argument.
// Depends on scl_pkg; holds the result in the output register.
`default_nettype none

module scl_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              line_valid,
   input  wire scl_pkg::line_type line_data,
   output logic                   line_ready,
   output logic                   rsp_valid,
   output logic [2:0]             rsp_command,
   output logic [31:0]            rsp_value,
   input  wire logic              rsp_ready
);

   logic        valid_ff, valid_in;
   logic [2:0]  command_ff;
   logic [31:0] value_ff;

   logic             issue;
   scl_pkg::cmd_type cmd;
   logic [31:0]      number;
   logic [31:0]      value;
   logic             neg;

   assign line_ready  = !valid_ff || rsp_ready;
   assign rsp_valid   = valid_ff;
   assign rsp_command = command_ff;
   assign rsp_value   = value_ff;

   always_comb begin
      if (line_data.negative) begin
         number = 32'd0 - line_data.magnitude;
      end else if (line_data.magnitude >= scl_pkg::MAG_LIMIT) begin
         number = scl_pkg::INT_MAX;
      end else begin
         number = line_data.magnitude;
      end
      neg   = number[31];
      issue = 1'b1;
      cmd   = scl_pkg::CMD_THRESHOLD;
      value = number;
      case (line_data.letter)
         scl_pkg::CHAR_T, scl_pkg::CHAR_S: begin
            cmd = scl_pkg::CMD_THRESHOLD;
         end
         scl_pkg::CHAR_M: begin
            cmd   = scl_pkg::CMD_MODE;
            value = {24'd0, number[7:0]};
         end
         scl_pkg::CHAR_B: begin
            cmd   = scl_pkg::CMD_BAND_MASK;
            value = {24'd0, number[7:0]};
         end
         scl_pkg::CHAR_F: begin
            cmd   = scl_pkg::CMD_BAND_SELECT;
            issue = !neg && (number <= scl_pkg::BAND_SEL_MAX);
         end
         scl_pkg::CHAR_V: begin
            cmd = scl_pkg::CMD_SERVO_HOLD;
            if (neg) begin
               value = '1;
            end else if (number > scl_pkg::SERVO_MAX) begin
               value = scl_pkg::SERVO_MAX;
            end
         end
         scl_pkg::CHAR_O: begin
            cmd   = scl_pkg::CMD_OSC_ENABLE;
            value = {31'd0, (number != '0)};
         end
         default: begin
            issue = 1'b0;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (line_valid && line_ready) begin
         valid_in = issue;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load the payload only for lines that give a command; drop the rest
   always_ff @(posedge clock) begin
      if (line_valid && line_ready && issue) begin
         command_ff <= cmd;
         value_ff   <= value;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/serial_command_line_parser.sv */
// Serial command line parser: one received byte per cycle while the queue is not full, at most one command per line.
// A CR or LF that ends a line pushes it into the queue; the back end then pops it into the output register.
// The multiply-by-ten update of the number is combinational shift-and-add logic.
// Reset (synchronous, active high) clears the line state, the queue and the output.
// Depends on scl_pkg, scl_front, scl_queue and scl_back.
`default_nettype none

module serial_command_line_parser #(
   parameter int LINE_BUFFER_BYTES = scl_pkg::LINE_BUFFER_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [2:0] command, [34:3] value, [39:35] zero
);

   scl_pkg::line_type push_data;
   scl_pkg::line_type pop_data;
   logic              push_valid;
   logic              queue_full;
   logic              pop_valid;
   logic              pop_ready;
   logic [2:0]        rsp_command;
   logic [31:0]       rsp_value;

   scl_front #(
      .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_data  (req_tdata),
      .queue_full (queue_full),
      .push_data  (push_data),
      .push_valid (push_valid),
      .byte_ready (req_tready)
   );

   scl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   scl_back u_back (
      .clock       (clock),
      .reset       (reset),
      .line_valid  (pop_valid),
      .line_data   (pop_data),
      .line_ready  (pop_ready),
      .rsp_valid   (rsp_tvalid),
      .rsp_command (rsp_command),
      .rsp_value   (rsp_value),
      .rsp_ready   (rsp_tready)
   );

   assign rsp_tdata = {5'd0, rsp_value, rsp_command};

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for serial_command_line_parser: random and directed command lines.
// A scoreboard class predicts each command from the accepted bytes; depends on scl_pkg.

import scl_pkg::*;

typedef struct {
   cmd_type     cmd;
   logic [31:0] value;
} command_item;

class command_scoreboard;
   localparam int KEEP_CHARS = LINE_BUFFER_BYTES_DEFAULT - 1;

   command_item pending_commands[$];
   int          fail_count;

   int          line_length;
   logic [7:0]  letter;
   bit          comma_seen;
   phase_type   phase;
   bit          negative;
   logic [31:0] magnitude;

   function new();
      fail_count = 0;
      clear_line();
   endfunction

   function void clear_line();
      line_length = 0;
      letter      = 8'h00;
      comma_seen  = 1'b0;
      phase       = PHASE_SKIP;
      negative    = 1'b0;
      magnitude   = 32'd0;
   endfunction

   function void feed_number(logic [7:0] c);
      logic [31:0] m;
      if (phase == PHASE_SKIP) begin
         if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF)
            return;
         if (c == CHAR_MINUS || c == CHAR_PLUS) begin
            negative = (c == CHAR_MINUS);
            phase    = PHASE_DIGITS;
            return;
         end
         phase = PHASE_DIGITS;
      end
      if (phase == PHASE_DIGITS) begin
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            if (magnitude >= MAG_SAT_START) begin
               magnitude = MAG_LIMIT;
            end else begin
               m = magnitude * 32'd10 + {24'd0, c - CHAR_ZERO};
               magnitude = (m > MAG_LIMIT) ? MAG_LIMIT : m;
            end
         end else begin
            phase = PHASE_DONE;
         end
      end
   endfunction

   // Update the line state for one accepted request; queue any command the line gives at line end
   function void note_byte(logic [7:0] c);
      command_item item;
      bit          issue;
      logic [31:0] v;
      if (c == CHAR_LF || c == CHAR_CR) begin
         if (line_length > 0 && comma_seen) begin
            v = negative ? (32'd0 - magnitude) : ((magnitude >= MAG_LIMIT) ? INT_MAX : magnitude);
            issue = 1'b1;
            item.cmd = CMD_THRESHOLD;
            case (letter)
               CHAR_T, CHAR_S: item.cmd = CMD_THRESHOLD;
               CHAR_M: begin
                  item.cmd = CMD_MODE;
                  v = v & 32'hFF;
               end
               CHAR_B: begin
                  item.cmd = CMD_BAND_MASK;
                  v = v & 32'hFF;
               end
               CHAR_F: begin
                  item.cmd = CMD_BAND_SELECT;
                  issue = !v[31] && v <= BAND_SEL_MAX;
               end
               CHAR_V: begin
                  item.cmd = CMD_SERVO_HOLD;
                  if (v[31])
                     v = 32'hFFFF_FFFF;
                  else if (v > SERVO_MAX)
                     v = SERVO_MAX;
               end
               CHAR_O: begin
                  item.cmd = CMD_OSC_ENABLE;
                  v = (v != 32'd0) ? 32'd1 : 32'd0;
               end
               default: issue = 1'b0;
            endcase
            if (issue) begin
               item.value = v;
               pending_commands.push_back(item);
            end
         end
         clear_line();
         return;
      end
      // Drop characters past the buffer until the terminator
      if (line_length < KEEP_CHARS) begin
         if (line_length == 0)
            letter = c;
         else if (line_length == 1)
            comma_seen = (c == CHAR_COMMA);
         else
            feed_number(c);
         line_length++;
      end
   endfunction

   task report(string msg);
      $display("MISMATCH: %s", msg);
      fail_count++;
   endtask

   task check_command(logic [39:0] data);
      command_item exp_item;
      if (pending_commands.size() == 0) begin
         report($sformatf("unexpected command %0d value %0d", data[2:0], $signed(data[34:3])));
         return;
      end
      exp_item = pending_commands.pop_front();
      if (data[2:0] != exp_item.cmd)
         report($sformatf("command got %0d want %0d", data[2:0], exp_item.cmd));
      if (data[34:3] != exp_item.value)
         report($sformatf("value got %0d want %0d (command %0d)",
                          $signed(data[34:3]), $signed(exp_item.value), exp_item.cmd));
      if (data[39:35] != 5'd0)
         report($sformatf("padding bits got %b", data[39:35]));
   endtask
endclass

module tb_top;
   localparam int RANDOM_BYTES = 1450;
   localparam int IDLE_PCT     = 17;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [2:0] command, [34:3] value, [39:35] zero

   command_scoreboard cmd_board = new();
   logic [7:0]        line_bytes[$];
   int                sent_count   = 0;
   bit                idle_enabled = 1'b1;

   serial_command_line_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         cmd_board.note_byte(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready)
         cmd_board.check_command(rsp_tdata);
      rsp_tready <= idle_enabled ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
   end

   task automatic send_byte(input logic [7:0] c);
      if (idle_enabled && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < IDLE_PCT);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   task automatic send_line();
      for (int i = 0; i < line_bytes.size(); i++)
         send_byte(line_bytes[i]);
      line_bytes.delete();
   endtask

   // Hold the request side until every queued command has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (cmd_board.pending_commands.size() != 0)
         @(posedge clock);
   endtask

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++)
         line_bytes.push_back(s[i]);
   endfunction

   function automatic void push_end();
      case ($urandom_range(0, 7))
         0: begin
            line_bytes.push_back(CHAR_CR);
            line_bytes.push_back(CHAR_LF);
         end
         1, 2, 3: line_bytes.push_back(CHAR_CR);
         default: line_bytes.push_back(CHAR_LF);
      endcase
   endfunction

   function automatic logic [7:0] pick_letter();
      case ($urandom_range(0, 6))
         0: return CHAR_T;
         1: return CHAR_S;
         2: return CHAR_M;
         3: return CHAR_B;
         4: return CHAR_F;
         5: return CHAR_V;
         default: return CHAR_O;
      endcase
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 3))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_VT;
         default: return CHAR_FF;
      endcase
   endfunction

   function automatic void push_number();
      string edge_values[6] = '{"2147483647", "2147483648", "2147483649",
                                "214748364", "214748365", "00000000000007"};
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
         line_bytes.push_back(pick_blank());
      case ($urandom_range(0, 3))
         0: line_bytes.push_back(CHAR_MINUS);
         1: line_bytes.push_back(CHAR_PLUS);
         default: ;
      endcase
      case ($urandom_range(0, 9))
         0: ;
         1, 2, 3, 4: push_text($sformatf("%0d", $urandom_range(0, 3)));
         5, 6: push_text($sformatf("%0d", $urandom_range(0, 1100)));
         7: push_text($sformatf("%0d", $urandom));
         8: push_text(edge_values[$urandom_range(0, 5)]);
         default: repeat ($urandom_range(1, 14))
            line_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      endcase
      // Trailing junk may end the number; it may include NUL or another terminator
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3))
            line_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void build_random_line();
      logic [7:0] c;
      int         kind;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         line_bytes.push_back(pick_letter());
         line_bytes.push_back(CHAR_COMMA);
         push_number();
      end else if (kind < 80) begin
         repeat ($urandom_range(0, 40))
            line_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 88) begin
         line_bytes.push_back(pick_letter());
         do c = 8'($urandom_range(0, 255));
         while (c == CHAR_COMMA || c == CHAR_CR || c == CHAR_LF);
         line_bytes.push_back(c);
         push_number();
      end else if (kind < 94) begin
         do c = 8'($urandom_range(0, 255));
         while (c == CHAR_CR || c == CHAR_LF || c == CHAR_T || c == CHAR_S || c == CHAR_M ||
                c == CHAR_B || c == CHAR_F || c == CHAR_V || c == CHAR_O);
         line_bytes.push_back(c);
         line_bytes.push_back(CHAR_COMMA);
         push_number();
      end else begin
         // Long line: leading zeros can push some or all digits past the kept length
         line_bytes.push_back(pick_letter());
         line_bytes.push_back(CHAR_COMMA);
         repeat ($urandom_range(20, 35)) line_bytes.push_back(CHAR_ZERO);
         repeat ($urandom_range(1, 12))
            line_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
      push_end();
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_text("T,-2147483649"); line_bytes.push_back(CHAR_LF);
      push_text("S, +7");         line_bytes.push_back(CHAR_CR);
      push_text("M,300");         line_bytes.push_back(CHAR_LF);
      push_text("B,-1");          line_bytes.push_back(CHAR_LF);
      push_text("F,2");           line_bytes.push_back(CHAR_LF);
      push_text("F,3");           line_bytes.push_back(CHAR_LF);
      push_text("V,-9");          line_bytes.push_back(CHAR_CR);
      push_text("V,5000");        line_bytes.push_back(CHAR_LF);
      push_text("O,x");           line_bytes.push_back(CHAR_LF);
      line_bytes.push_back(CHAR_LF);
      push_text("X,1");           line_bytes.push_back(CHAR_LF);
      push_text("T5");            line_bytes.push_back(CHAR_LF);
      push_text("T,12"); line_bytes.push_back(8'h00); push_text("3"); line_bytes.push_back(CHAR_LF);
      push_text("T,99999999999"); line_bytes.push_back(CHAR_LF);
      send_line();
      wait_drained();

      sent_count = 0;
      while (sent_count < RANDOM_BYTES) begin
         idle_enabled = !(sent_count > 300 && sent_count < 650);
         build_random_line();
         send_line();
         if (sent_count > 900 && sent_count < 960)
            wait_drained();
      end
      idle_enabled = 1'b1;
      wait_drained();
      repeat (4) @(posedge clock);

      if (cmd_board.pending_commands.size() != 0)
         cmd_board.report($sformatf("%0d expected commands never came",
                                    cmd_board.pending_commands.size()));
      if (cmd_board.fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

/* serial_command_line_parser.f */
hw/rtl/scl_pkg.sv
hw/rtl/scl_front.sv
hw/rtl/scl_queue.sv
hw/rtl/scl_back.sv
hw/rtl/serial_command_line_parser.sv
tb/sv/tb_top.sv
